### sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rms_pkg.sv
// Package for the resistance motion sequencer: widths, codes, register
// indexes, controller states and the control/status structs. No dependencies.
package rms_pkg;

    localparam int FORCE_BITS = 12;
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = FORCE_BITS + COUNT_BITS;
    // count * 100 needs 7 more bits than the count
    localparam int DIVR_BITS  = COUNT_BITS + 7;
    localparam int ITER_BITS  = $clog2(SUM_BITS);
    localparam int FLEX90_BITS = 20;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CALIB_TIME = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TIME  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REQUIRED   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPLIT      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_PWM   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PWM    = 3'd7;

    // drive direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // phase codes
    localparam logic [1:0] PH_CALIB = 2'd0;
    localparam logic [1:0] PH_MOVE  = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;

    localparam logic [7:0] PWM_MAX = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DIV
    } ctrl_state_t;

    typedef struct packed {
        logic accept;     // sample transfer this cycle
        logic div_start;  // launch average division
        logic lock;       // latch clamped pwm from quotient
    } rms_cmd_t;

    typedef struct packed {
        logic calib_end;  // current sample ends calibration
        logic div_done;   // quotient ready
    } rms_sts_t;

endpackage

### sv/rms_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rms_pkg.
module rms_div
    import rms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_BITS-1:0]  dividend,
    input  logic [DIVR_BITS-1:0] divisor,
    output logic                 done,
    output logic [SUM_BITS-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic [SUM_BITS-1:0]  quo_reg, quo_next;
    logic [DIVR_BITS-1:0] rem_reg, rem_next;
    logic [DIVR_BITS-1:0] dvs_reg, dvs_next;
    logic [DIVR_BITS:0]   rem_try;
    logic                 fits;

    assign rem_try = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits    = rem_try >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_BITS-2:0], fits};
            rem_next = fits ? DIVR_BITS'(rem_try - {1'b0, dvs_reg})
                            : rem_try[DIVR_BITS-1:0];
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_BITS'(SUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/rms_datapath.sv
// Datapath: config registers, sequencer state, result register and the
// average divider. Depends on rms_pkg and rms_div.
module rms_datapath
    import rms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  rms_cmd_t              cmd,
    output rms_sts_t              sts,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // configuration
    logic [15:0] calib_time_reg;
    logic [15:0] hold_time_reg;
    logic [3:0]  required_reg;
    logic [6:0]  top_reg;
    logic [6:0]  bottom_reg;
    logic [6:0]  split_reg;
    logic [7:0]  base_pwm_reg;
    logic [7:0]  min_pwm_reg;

    // sequencer state
    logic                  started_reg, started_next;
    logic [31:0]           calib_start_reg, calib_start_next;
    logic                  calibrating_reg, calibrating_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [7:0]            locked_pwm_reg, locked_pwm_next;
    logic                  dir_up_reg, dir_up_next;
    logic                  first_chosen_reg, first_chosen_next;
    logic                  holding_reg, holding_next;
    logic [31:0]           hold_start_reg, hold_start_next;
    logic [3:0]            arrival_reg, arrival_next;
    logic                  en_reg, en_next;
    logic [7:0]            pwm_reg, pwm_next;
    logic [1:0]            dir_reg, dir_next;
    logic [1:0]            phase_reg, phase_next;

    // sample fields
    logic [31:0]           now_ms;
    logic [11:0]           force_raw;
    logic [12:0]           flex_level;
    logic [FORCE_BITS-1:0] force_m;
    logic [FLEX90_BITS-1:0] flex90;

    logic [31:0]           cst;
    logic [SUM_BITS:0]     sum_add;
    logic                  calib_done;
    logic                  calib_end;
    logic                  hold_done;
    logic                  dir_up_eff;
    logic                  in_target;
    logic [3:0]            arr_upd;

    // division and clamp
    logic [COUNT_BITS-1:0] count_eff;
    logic [DIVR_BITS-1:0]  divisor;
    logic                  div_done;
    logic [SUM_BITS-1:0]   quotient;
    logic [8:0]            pwm_sum;
    logic [8:0]            pwm_lo;
    logic [7:0]            pwm_clamped;

    assign now_ms     = s_tdata[31:0];
    assign force_raw  = s_tdata[43:32];
    assign flex_level = s_tdata[56:44];
    assign force_m    = FORCE_BITS'(force_raw);
    assign flex90     = FLEX90_BITS'(flex_level) * FLEX90_BITS'(90);

    assign cst        = started_reg ? calib_start_reg : now_ms;
    assign sum_add    = {1'b0, sum_reg} + (SUM_BITS + 1)'(force_m);
    assign calib_done = (now_ms - cst) >= {16'd0, calib_time_reg};
    assign hold_done  = (now_ms - hold_start_reg) >= {16'd0, hold_time_reg};
    assign dir_up_eff = first_chosen_reg ? dir_up_reg
                      : !(flex90 > {1'b0, split_reg, 12'd0});
    assign in_target  = dir_up_eff ? (flex90 >= {1'b0, top_reg, 12'd0})
                                   : (flex90 <= {1'b0, bottom_reg, 12'd0});
    assign arr_upd    = !in_target ? 4'd0
                      : (arrival_reg == 4'd15) ? 4'd15 : arrival_reg + 4'd1;

    always_comb
    begin
        started_next      = started_reg;
        calib_start_next  = calib_start_reg;
        calibrating_next  = calibrating_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        dir_up_next       = dir_up_reg;
        first_chosen_next = first_chosen_reg;
        holding_next      = holding_reg;
        hold_start_next   = hold_start_reg;
        arrival_next      = arrival_reg;
        en_next           = en_reg;
        pwm_next          = pwm_reg;
        dir_next          = dir_reg;
        phase_next        = phase_reg;
        calib_end         = 1'b0;
        if (cmd.accept)
        begin
            started_next     = 1'b1;
            calib_start_next = cst;
            if (calibrating_reg)
            begin
                sum_next   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
                en_next    = 1'b0;
                pwm_next   = 8'd0;
                dir_next   = DIR_STOP;
                phase_next = PH_CALIB;
                if (calib_done)
                begin
                    calibrating_next = 1'b0;
                    phase_next       = PH_MOVE;
                    calib_end        = 1'b1;
                end
            end
            else
            begin
                first_chosen_next = 1'b1;
                dir_up_next       = dir_up_eff;
                if (holding_reg)
                begin
                    en_next    = 1'b0;
                    pwm_next   = 8'd0;
                    dir_next   = DIR_STOP;
                    phase_next = PH_HOLD;
                    if (hold_done)
                    begin
                        holding_next = 1'b0;
                        dir_up_next  = !dir_up_eff;
                        arrival_next = 4'd0;
                        phase_next   = PH_MOVE;
                    end
                end
                else if (arr_upd >= required_reg)
                begin
                    // arrival: keep previous drive on this sample
                    holding_next    = 1'b1;
                    hold_start_next = now_ms;
                    arrival_next    = 4'd0;
                    phase_next      = PH_HOLD;
                end
                else
                begin
                    arrival_next = arr_upd;
                    en_next      = 1'b1;
                    pwm_next     = locked_pwm_reg;
                    dir_next     = dir_up_eff ? DIR_FWD : DIR_REV;
                    phase_next   = PH_MOVE;
                end
            end
        end
    end

    // average = sum / (count * 100); count never zero here but guard anyway
    assign count_eff = (count_reg == '0) ? COUNT_BITS'(1) : count_reg;
    assign divisor   = DIVR_BITS'(count_eff) * DIVR_BITS'(100);

    rms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts = '{calib_end: calib_end, div_done: div_done};

    assign pwm_sum = {1'b0, base_pwm_reg} + {1'b0, quotient[7:0]};
    assign pwm_lo  = (pwm_sum < {1'b0, min_pwm_reg}) ? {1'b0, min_pwm_reg} : pwm_sum;
    assign pwm_clamped = (|quotient[SUM_BITS-1:8] || pwm_lo[8]) ? PWM_MAX : pwm_lo[7:0];
    assign locked_pwm_next = cmd.lock ? pwm_clamped : locked_pwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_time_reg <= 16'd5000;
            hold_time_reg  <= 16'd5000;
            required_reg   <= 4'd4;
            top_reg        <= 7'd90;
            bottom_reg     <= 7'd6;
            split_reg      <= 7'd50;
            base_pwm_reg   <= 8'd120;
            min_pwm_reg    <= 8'd80;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CALIB_TIME: calib_time_reg <= cfg_wdata;
                REG_HOLD_TIME:  hold_time_reg  <= cfg_wdata;
                REG_REQUIRED:   required_reg   <= cfg_wdata[3:0];
                REG_TOP:        top_reg        <= cfg_wdata[6:0];
                REG_BOTTOM:     bottom_reg     <= cfg_wdata[6:0];
                REG_SPLIT:      split_reg      <= cfg_wdata[6:0];
                REG_BASE_PWM:   base_pwm_reg   <= cfg_wdata[7:0];
                REG_MIN_PWM:    min_pwm_reg    <= cfg_wdata[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            calib_start_reg  <= '0;
            calibrating_reg  <= 1'b1;
            sum_reg          <= '0;
            count_reg        <= '0;
            locked_pwm_reg   <= 8'd120;
            dir_up_reg       <= 1'b1;
            first_chosen_reg <= 1'b0;
            holding_reg      <= 1'b0;
            hold_start_reg   <= '0;
            arrival_reg      <= '0;
            en_reg           <= 1'b0;
            pwm_reg          <= '0;
            dir_reg          <= DIR_STOP;
            phase_reg        <= PH_CALIB;
        end
        else
        begin
            started_reg      <= started_next;
            calib_start_reg  <= calib_start_next;
            calibrating_reg  <= calibrating_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            locked_pwm_reg   <= locked_pwm_next;
            dir_up_reg       <= dir_up_next;
            first_chosen_reg <= first_chosen_next;
            holding_reg      <= holding_next;
            hold_start_reg   <= hold_start_next;
            arrival_reg      <= arrival_next;
            en_reg           <= en_next;
            pwm_reg          <= pwm_next;
            dir_reg          <= dir_next;
            phase_reg        <= phase_next;
        end
    end

    assign m_tdata = {3'd0, phase_reg, dir_reg, pwm_reg, en_reg};

endmodule

### sv/rms_ctrl.sv
// Controller: stream handshakes, output valid and the divide sequence.
// Depends on rms_pkg.
module rms_ctrl
    import rms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  rms_sts_t sts,
    output rms_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        ready;
    logic        accept;

    assign ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept = s_tvalid && ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.calib_end)
                begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.accept    = accept;
        cmd.div_start = (state_reg == ST_DSTART);
        cmd.lock      = (state_reg == ST_DIV) && sts.div_done;
        s_tready      = ready;
        m_tvalid      = out_valid_reg;
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/resistance_motion_sequencer.sv
// Top level of the resistance motion sequencer: controller plus datapath.
// Depends on rms_pkg, rms_ctrl, rms_datapath (and rms_div), assert_macros.svh.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------
//  s_*      | in        | one sample per transfer
//  m_*      | out       | one drive result per sample
//  cfg_*    | in        | register write, index and data, no read-back
//
// The result is registered at the transfer edge and the next sample is
// taken while that result waits, provided m_tready frees the result
// register in the same cycle.
// The sample that ends calibration starts the average divide; s_tready then
// stays low through the ST_DSTART and ST_DIV states, while the
// one-bit-per-cycle divider produces the locked pwm duty.
// Reset is asynchronous, active low, and restores the register defaults.
`include "assert_macros.svh"

module resistance_motion_sequencer
    import rms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // now_ms[31:0], force_raw[43:32],
                                            // flex_level[56:44], zeros above
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // drive_enable[0], drive_pwm[8:1],
                                            // drive_dir[10:9], phase[12:11]
);

    rms_cmd_t cmd;
    rms_sts_t sts;

    rms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rms_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

    // calibration end must launch the divide on the following cycle
    `ASSERT_NEXT(a_div_launch, cmd.accept && sts.calib_end, cmd.div_start, "divide not launched")
    // no sample may slip in while div_done signals the quotient ready
    `ASSERT_IMPLIES(a_no_take_in_div, sts.div_done, !s_tready, "sample taken during divide")
    // calibration end result: motors off, phase moving
    `ASSERT_NEXT(a_calib_end_out, cmd.accept && sts.calib_end, !m_tdata[0] && m_tdata[12:11] == PH_MOVE, "bad calibration end result")
    // enabled drive always carries a direction
    `ASSERT_IMPLIES(a_en_has_dir, m_tvalid && m_tdata[0], m_tdata[10:9] != DIR_STOP, "drive enabled with stop")

endmodule

### sim/rms_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the resistance motion sequencer: watches config, sample and result channels,
// predicts each drive result and compares it. Depends on rms_pkg only.
module rms_checker
    import rms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending,
    output int                    results_checked,
    output int                    holds_entered
);

    // lowest member last, so this matches m_tdata[12:0]
    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] dir;
        logic [7:0] pwm;
        logic       en;
    } drive_result_t;

    // shadow registers
    logic [15:0] calib_ms, hold_ms;
    logic [3:0]  need_in;
    logic [6:0]  top_deg, bot_deg, split_deg;
    logic [7:0]  base_duty, min_duty;

    // shadow sequencer state
    logic                  seen_first, in_calib, going_up, dir_picked, in_hold;
    logic [31:0]           calib_t0, hold_t0;
    logic [SUM_BITS-1:0]   force_acc;
    logic [COUNT_BITS-1:0] force_n;
    logic [7:0]            duty_lock;
    logic [3:0]            in_target_run;
    logic                  last_en;
    logic [7:0]            last_pwm;
    logic [1:0]            last_dir;

    drive_result_t expected_drives[$];
    drive_result_t want;

    task automatic flag_mismatch(input string what, input int exp_val, input int got_val);
        // keep the log short if the block is badly broken
        if (fail_count < 40)
            $display("%0t ns: mismatch on %s, expected %0d, got %0d",
                     $time, what, exp_val, got_val);
        fail_count++;
    endtask

    // Next drive result for one sample; advances the shadow state.
    function automatic drive_result_t predict_drive(input logic [IN_DATA_W-1:0] d);
        logic [31:0]           t;
        logic [31:0]           span;
        logic [FORCE_BITS-1:0] f;
        logic [31:0]           flex90;
        logic [SUM_BITS:0]     acc;
        logic [31:0]           duty;
        logic                  hit;
        drive_result_t         r;
        t      = d[31:0];
        f      = d[43:32];
        flex90 = 32'(d[56:44]) * 32'd90;
        r.phase = PH_MOVE;
        if (!seen_first)
        begin
            seen_first = 1'b1;
            calib_t0   = t;
        end
        if (in_calib)
        begin
            acc       = force_acc + f;
            force_acc = acc[SUM_BITS] ? {SUM_BITS{1'b1}} : acc[SUM_BITS-1:0];
            if (force_n != {COUNT_BITS{1'b1}})
                force_n = force_n + 1'b1;
            last_en  = 1'b0;
            last_pwm = 8'd0;
            last_dir = DIR_STOP;
            r.phase  = PH_CALIB;
            span = t - calib_t0;
            if (span >= 32'(calib_ms))
            begin
                duty = 32'(base_duty) + 32'(force_acc) / (32'(force_n) * 32'd100);
                if (duty < 32'(min_duty))
                    duty = 32'(min_duty);
                if (duty > 32'(PWM_MAX))
                    duty = 32'(PWM_MAX);
                duty_lock = duty[7:0];
                in_calib  = 1'b0;
                r.phase   = PH_MOVE;
            end
        end
        else
        begin
            if (!dir_picked)
            begin
                going_up   = !(flex90 > 32'(split_deg) * 32'd4096);
                dir_picked = 1'b1;
            end
            if (in_hold)
            begin
                last_en  = 1'b0;
                last_pwm = 8'd0;
                last_dir = DIR_STOP;
                r.phase  = PH_HOLD;
                span = t - hold_t0;
                if (span >= 32'(hold_ms))
                begin
                    in_hold       = 1'b0;
                    going_up      = !going_up;
                    in_target_run = 4'd0;
                    r.phase       = PH_MOVE;
                end
            end
            else
            begin
                hit = going_up ? (flex90 >= 32'(top_deg) * 32'd4096)
                               : (flex90 <= 32'(bot_deg) * 32'd4096);
                if (!hit)
                    in_target_run = 4'd0;
                else if (in_target_run != 4'd15)
                    in_target_run = in_target_run + 1'b1;
                if (in_target_run >= need_in)
                begin
                    // drive fields of the previous result carry over
                    in_hold       = 1'b1;
                    hold_t0       = t;
                    in_target_run = 4'd0;
                    r.phase       = PH_HOLD;
                    holds_entered++;
                end
                else
                begin
                    last_en  = 1'b1;
                    last_pwm = duty_lock;
                    last_dir = going_up ? DIR_FWD : DIR_REV;
                end
            end
        end
        r.en  = last_en;
        r.pwm = last_pwm;
        r.dir = last_dir;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_ms  = 16'd5000;
            hold_ms   = 16'd5000;
            need_in   = 4'd4;
            top_deg   = 7'd90;
            bot_deg   = 7'd6;
            split_deg = 7'd50;
            base_duty = 8'd120;
            min_duty  = 8'd80;
            seen_first    = 1'b0;
            in_calib      = 1'b1;
            going_up      = 1'b1;
            dir_picked    = 1'b0;
            in_hold       = 1'b0;
            calib_t0      = 32'd0;
            hold_t0       = 32'd0;
            force_acc     = '0;
            force_n       = '0;
            duty_lock     = 8'd120;
            in_target_run = 4'd0;
            last_en       = 1'b0;
            last_pwm      = 8'd0;
            last_dir      = DIR_STOP;
            expected_drives.delete();
            fail_count      = 0;
            results_checked = 0;
            holds_entered   = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CALIB_TIME: calib_ms  = cfg_wdata;
                    REG_HOLD_TIME:  hold_ms   = cfg_wdata;
                    REG_REQUIRED:   need_in   = cfg_wdata[3:0];
                    REG_TOP:        top_deg   = cfg_wdata[6:0];
                    REG_BOTTOM:     bot_deg   = cfg_wdata[6:0];
                    REG_SPLIT:      split_deg = cfg_wdata[6:0];
                    REG_BASE_PWM:   base_duty = cfg_wdata[7:0];
                    REG_MIN_PWM:    min_duty  = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_drives.push_back(predict_drive(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_drives.size() == 0)
                    flag_mismatch("result with nothing expected", 0, m_tdata);
                else
                begin
                    want = expected_drives.pop_front();
                    if (m_tdata[0] !== want.en)
                        flag_mismatch("drive_enable", want.en, m_tdata[0]);
                    if (m_tdata[8:1] !== want.pwm)
                        flag_mismatch("drive_pwm", want.pwm, m_tdata[8:1]);
                    if (m_tdata[10:9] !== want.dir)
                        flag_mismatch("drive_dir", want.dir, m_tdata[10:9]);
                    if (m_tdata[12:11] !== want.phase)
                        flag_mismatch("phase", want.phase, m_tdata[12:11]);
                    if (m_tdata[OUT_DATA_W-1:13] !== '0)
                        flag_mismatch("tdata padding", 0, m_tdata[OUT_DATA_W-1:13]);
                    results_checked++;
                end
            end
            pending <= expected_drives.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Top of the resistance motion sequencer testbench: clock, reset, sample and config stimulus,
// result backpressure and verdict. Depends on rms_pkg, rms_checker and the block itself.
module testbench;
    import rms_pkg::*;

    // Samples in the calibration soak at full-scale force.
    localparam int SOAK_SAMPLES = 300;
    // Samples sent for each register setting.
    localparam int SETTING_SAMPLES = 160;
    // Idle cycles after the last result before touching registers: the
    // average divide keeps the block busy.
    localparam int SETTLE_CYCLES = 40;
    // Slowest correct run: ~1.8k samples, each with the longest idle gaps on
    // either side plus its own transfer, takes about 4.6 ms; about five times that.
    localparam int RUN_LIMIT_NS = 25_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int results_checked;
    int holds_entered;

    // stimulus bookkeeping
    logic [31:0] now_ms = 32'd0;
    bit          calm   = 1'b0;     // no idling on either side while set
    int          stall_left = 0;
    int          settings_run = 0;

    always #10 clk = ~clk;

    resistance_motion_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rms_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .holds_entered   (holds_entered)
    );

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side backpressure: random stalls, none while calm.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    // One sample transfer, preceded by a random gap unless calm. Returns in the
    // time step of the accepting edge; s_tvalid stays high so back-to-back
    // samples do not glitch it.
    task automatic send_sample(input logic [31:0] t, input logic [11:0] f,
                               input logic [12:0] x);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, x, f, t};   // flex_level, force_raw, now_ms
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending, let every expected result drain, then let the block
    // go quiet before anything else happens.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // All eight registers, one write transfer per cycle.
    task automatic program_regs(input logic [15:0] calib, input logic [15:0] hold,
                                input logic [15:0] need, input logic [15:0] top,
                                input logic [15:0] bot, input logic [15:0] split,
                                input logic [15:0] base, input logic [15:0] minp);
        logic [CFG_ADDR_W-1:0] idx [8];
        logic [15:0]           val [8];
        int                    i;
        idx = '{REG_CALIB_TIME, REG_HOLD_TIME, REG_REQUIRED, REG_TOP,
                REG_BOTTOM, REG_SPLIT, REG_BASE_PWM, REG_MIN_PWM};
        val = '{calib, hold, need, top, bot, split, base, minp};
        for (i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random moving/holding traffic. Flex readings come in runs aimed at the
    // top target, the bottom target, the gap between them, or anywhere, so
    // in-target streaks long enough to reach a hold happen often; strays and
    // time jumps break the streaks now and then.
    task automatic run_setting(input int n, input int top, input int bot, input int max_step);
        int hi_min, lo_max, zone, run_left, flex, i;
        hi_min = (top * 4096 + 89) / 90;   // smallest flex at or above top
        lo_max = (bot * 4096) / 90;        // largest flex at or below bottom
        run_left = 0;
        zone     = 0;
        for (i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 18);
                zone     = $urandom_range(0, 99);
                calm     = ($urandom_range(0, 9) == 0);
            end
            run_left--;
            if (zone < 38)
                flex = ($urandom_range(0, 5) == 0) ? hi_min : $urandom_range(hi_min, 8191);
            else if (zone < 76)
                flex = ($urandom_range(0, 5) == 0) ? lo_max : $urandom_range(0, lo_max);
            else if (zone < 88 && lo_max + 1 < hi_min)
                flex = $urandom_range(lo_max + 1, hi_min - 1);
            else
                flex = $urandom_range(0, 8191);
            if ($urandom_range(0, 19) == 0)
                flex = $urandom_range(0, 8191);
            if ($urandom_range(0, 49) == 0)
                now_ms = $urandom();
            else
                now_ms = now_ms + $urandom_range(0, max_step);
            send_sample(now_ms, 12'($urandom_range(0, 4095)), 13'(flex));
        end
    endtask

    // New register setting on an idle block, then traffic for it.
    task automatic apply_and_run(input int calib, input int hold, input int need,
                                 input int top, input int bot, input int split,
                                 input int base, input int minp, input int n,
                                 input int max_step);
        settle();
        program_regs(16'(calib), 16'(hold), 16'(need), 16'(top), 16'(bot),
                     16'(split), 16'(base), 16'(minp));
        run_setting(n, top & 127, bot & 127, max_step);
        settings_run++;
    endtask

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [31:0] t0;
        int          elapsed;
        int          k;
        int          hold, need, top, bot;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Longest calibration, base pwm high enough that the lock clamps at
        // the top; move targets 80 / 10 degrees, three readings to arrive.
        program_regs(16'd65535, 16'd20, 16'd3, 16'd80, 16'd10, 16'd50, 16'd230, 16'd100);
        settings_run++;

        // Calibration starts close to the 32-bit wrap so the elapsed-time
        // difference crosses it. First sample starts the timer.
        t0 = 32'hFFFF_C000;
        now_ms = t0;
        calm = 1'b1;
        send_sample(now_ms, 12'h000, 13'd0);
        send_sample(now_ms, 12'hFFF, 13'h1FFF);
        now_ms = now_ms + 1;
        send_sample(now_ms, 12'hAAA, 13'h0AAA);
        send_sample(now_ms, 12'h555, 13'h1555);
        now_ms = now_ms + 1;
        send_sample(now_ms, 12'hFFF, 13'd4096);
        elapsed = 2;

        // Soak at full-scale force; time creeps but stays short of the
        // calibration length.
        for (k = 0; k < SOAK_SAMPLES; k++)
        begin
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) != 0);
            if (elapsed < 65534 && $urandom_range(0, 1) == 1)
            begin
                now_ms = now_ms + 1;
                elapsed++;
            end
            send_sample(now_ms, 12'hFFF, 13'($urandom_range(0, 8191)));
        end

        // Exactly calib_time after the first sample: calibration ends here
        // and the divide runs (sender is held off meanwhile).
        now_ms = t0 + 32'd65535;
        send_sample(now_ms, 12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));

        // First moving sample: bent past the split angle, so it heads down.
        now_ms = now_ms + 1;
        send_sample(now_ms, 12'd0, 13'h1FFF);
        // Three at the bottom: hold starts on the third (drive repeated).
        repeat (3)
        begin
            now_ms = now_ms + 1;
            send_sample(now_ms, 12'd0, 13'd0);
        end
        // Still holding, then hold ends after 20 ms and direction flips up.
        now_ms = now_ms + 5;
        send_sample(now_ms, 12'd0, 13'd0);
        now_ms = now_ms + 15;
        send_sample(now_ms, 12'd0, 13'd0);
        // Up to the top: 3641 is the first flex at or above 80 degrees.
        now_ms = now_ms + 1;
        send_sample(now_ms, 12'd0, 13'd3640);
        repeat (3)
        begin
            now_ms = now_ms + 1;
            send_sample(now_ms, 12'd0, 13'd3641);
        end
        now_ms = now_ms + 25;
        send_sample(now_ms, 12'd0, 13'd4096);
        now_ms = now_ms + 1;
        send_sample(now_ms, 12'hFFF, 13'd8191);

        // Fixed corners of the register space.
        // Everything zero: immediate hold ends, one reading to arrive.
        apply_and_run(0, 0, 1, 0, 0, 0, 0, 0, SETTING_SAMPLES, 3);
        // Longest hold with large time steps, fifteen readings to arrive.
        apply_and_run(65535, 65535, 15, 90, 90, 90, 255, 0, SETTING_SAMPLES, 30000);
        // Zero readings required (arrival on every moving sample), angles
        // past full bend.
        apply_and_run(1234, 37, 0, 127, 127, 127, 255, 255, SETTING_SAMPLES, 15);
        // Both targets at 45 degrees, where flex 2048 sits exactly on them.
        apply_and_run(5000, 10, 2, 45, 45, 50, 120, 80, SETTING_SAMPLES, 5);

        // Random settings; narrow registers get junk in their upper bits.
        for (k = 0; k < 5; k++)
        begin
            hold = $urandom_range(0, 200);
            need = $urandom_range(1, 15);
            top  = ($urandom_range(0, 4) == 0) ? $urandom_range(91, 127) : $urandom_range(0, 90);
            bot  = ($urandom_range(0, 4) == 0) ? $urandom_range(91, 127) : $urandom_range(0, 90);
            apply_and_run($urandom_range(0, 65535), hold,
                          need | ($urandom_range(0, 4095) << 4),
                          top | ($urandom_range(0, 511) << 7),
                          bot | ($urandom_range(0, 511) << 7),
                          $urandom_range(0, 127) | ($urandom_range(0, 511) << 7),
                          $urandom_range(0, 255) | ($urandom_range(0, 255) << 8),
                          $urandom_range(0, 255) | ($urandom_range(0, 255) << 8),
                          SETTING_SAMPLES, hold / 3 + 2);
        end

        settle();
        $display("Run covered a %0d-sample calibration soak, %0d register settings",
                 SOAK_SAMPLES, settings_run);
        $display("and %0d target arrivals; %0d drive results checked, %0d mismatches",
                 holds_entered, results_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/rms_pkg.sv
sv/rms_div.sv
sv/rms_datapath.sv
sv/rms_ctrl.sv
sv/resistance_motion_sequencer.sv
sim/rms_checker.sv
sim/testbench.sv
